// ----- src/wec_pkg.sv -----
// ----------------------------------------------------------------------------
// wec_pkg
// Shared types and constants of the waveform event charge integrator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wec_pkg;

    localparam logic [31:0] HEADER_MARK = 32'hFFFF_DDDD;
    localparam int          SKIP_W      = 3;

    localparam int ACC_W    = 24;
    localparam int CHARGE_W = 23;

    localparam int WIN_W   = 11;
    localparam int PED_W   = 12;
    localparam int SHIFT_W = 4;
    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = 12;

    localparam logic [CFG_IW-1:0] REG_WINDOW_START = 2'd0;
    localparam logic [CFG_IW-1:0] REG_WINDOW_END   = 2'd1;
    localparam logic [CFG_IW-1:0] REG_PEDESTAL     = 2'd2;
    localparam logic [CFG_IW-1:0] REG_CHARGE_SHIFT = 2'd3;

    localparam logic [WIN_W-1:0]   RST_WINDOW_START = 11'd20;
    localparam logic [WIN_W-1:0]   RST_WINDOW_END   = 11'd120;
    localparam logic [PED_W-1:0]   RST_PEDESTAL     = 12'd100;
    localparam logic [SHIFT_W-1:0] RST_CHARGE_SHIFT = 4'd4;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;
    // entries in use, held word's results included, that leave room for the next word
    localparam int FIFO_LIMIT = 2;

    typedef struct packed {
        logic [WIN_W-1:0]   window_start;
        logic [WIN_W-1:0]   window_end;
        logic [PED_W-1:0]   pedestal;
        logic [SHIFT_W-1:0] charge_shift;
    } t_cfg;

    typedef struct packed {
        logic                    channel;
        logic                    last;
        logic signed [ACC_W-1:0] sum;
    } t_result;

    // floor shift of the sum, saturated to the charge width
    function automatic logic signed [CHARGE_W-1:0] charge_of(
        input logic signed [ACC_W-1:0] sum,
        input logic [SHIFT_W-1:0]      sh
    );
        logic signed [ACC_W-1:0]    v;
        logic signed [CHARGE_W-1:0] r;
        v = sum >>> sh;
        if (v[ACC_W-1] != v[CHARGE_W-1]) begin
            r = v[ACC_W-1] ? {1'b1, {(CHARGE_W-1){1'b0}}} : {1'b0, {(CHARGE_W-1){1'b1}}};
        end else begin
            r = v[CHARGE_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/waveform_event_charge_integrator.sv -----
// ----------------------------------------------------------------------------
// waveform_event_charge_integrator
// Finds an event header in a word stream, skips the header, reads the sample
// count and sums the pedestal-subtracted samples inside the cell window of
// each of the two channels; emits one shifted charge per channel.
//
//   channel  direction  handshake             payload
//   input    in         i_valid / o_stall     i_word
//   result   out        o_valid / i_stall     o_channel, o_charge, o_last
//   config   in         i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
// One word per cycle while o_stall is low; a word's results are written to the
// result queue at the edge after its transfer; readable from the next cycle on.
// o_stall rises while the four-entry result queue could not take the results
// of the word held in the input register plus those of one more word.
// Reset (synchronous, active low) empties the queue and returns to header hunt.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module waveform_event_charge_integrator #(
    parameter int MAX_CELLS   = 1024,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [31:0]                       i_word,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic                                   o_channel,
    output logic signed [wec_pkg::CHARGE_W-1:0]    o_charge,
    output logic                                   o_last,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [wec_pkg::CFG_IW-1:0]        i_cfg_index,
    input  wire logic [wec_pkg::CFG_DW-1:0]        i_cfg_data
);

    wec_pkg::t_cfg                   cfg;
    logic                            push0;
    logic                            push1;
    wec_pkg::t_result                res0;
    wec_pkg::t_result                res1;
    wec_pkg::t_result                head;
    logic [wec_pkg::FIFO_CW-1:0]     count;
    logic [wec_pkg::FIFO_CW:0]       reserved;

    wec_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    wec_core #(
        .MAX_CELLS   (MAX_CELLS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid && !o_stall),
        .i_word  (i_word),
        .i_cfg   (cfg),
        .o_push0 (push0),
        .o_push1 (push1),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    wec_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (push0),
        .i_push1 (push1),
        .i_res0  (res0),
        .i_res1  (res1),
        .o_valid (o_valid),
        .i_pop   (!i_stall),
        .o_res   (head),
        .o_count (count)
    );

    assign reserved  = {1'b0, count} + (wec_pkg::FIFO_CW+1)'(push0)
                     + (wec_pkg::FIFO_CW+1)'(push1);
    assign o_stall   = (reserved > (wec_pkg::FIFO_CW+1)'(wec_pkg::FIFO_LIMIT));
    assign o_channel = head.channel;
    assign o_last    = head.last;
    assign o_charge  = wec_pkg::charge_of(head.sum, cfg.charge_shift);

endmodule

`default_nettype wire

// ----- src/wec_cfg.sv -----
// ----------------------------------------------------------------------------
// wec_cfg
// Configuration registers: window bounds, pedestal and charge shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wec_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [wec_pkg::CFG_IW-1:0]  i_cfg_index,
    input  wire logic [wec_pkg::CFG_DW-1:0]  i_cfg_data,
    output wec_pkg::t_cfg                    o_cfg
);

    wec_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_start <= wec_pkg::RST_WINDOW_START;
            r_cfg.window_end   <= wec_pkg::RST_WINDOW_END;
            r_cfg.pedestal     <= wec_pkg::RST_PEDESTAL;
            r_cfg.charge_shift <= wec_pkg::RST_CHARGE_SHIFT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                wec_pkg::REG_WINDOW_START: begin
                    r_cfg.window_start <= i_cfg_data[wec_pkg::WIN_W-1:0];
                end
                wec_pkg::REG_WINDOW_END: begin
                    r_cfg.window_end <= i_cfg_data[wec_pkg::WIN_W-1:0];
                end
                wec_pkg::REG_PEDESTAL: begin
                    r_cfg.pedestal <= i_cfg_data[wec_pkg::PED_W-1:0];
                end
                wec_pkg::REG_CHARGE_SHIFT: begin
                    r_cfg.charge_shift <= i_cfg_data[wec_pkg::SHIFT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- src/wec_core.sv -----
// ----------------------------------------------------------------------------
// wec_core
// Input register and event parser: header hunt, header skip, sample count,
// windowed pedestal-subtracted sum per channel with saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wec_core #(
    parameter int MAX_CELLS   = 1024,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [31:0]   i_word,
    input  wec_pkg::t_cfg      i_cfg,
    output logic               o_push0,
    output logic               o_push1,
    output wec_pkg::t_result   o_res0,
    output wec_pkg::t_result   o_res1
);

    localparam int CW    = $clog2(MAX_CELLS + 1);
    localparam int CMPW  = (CW > wec_pkg::WIN_W) ? CW : wec_pkg::WIN_W;
    localparam int DW    = ((SAMPLE_BITS > wec_pkg::PED_W) ? SAMPLE_BITS : wec_pkg::PED_W) + 1;
    localparam int ACC_W = wec_pkg::ACC_W;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SKIP,
        PH_COUNT,
        PH_DATA
    } t_phase;

    logic                            r_in_valid;
    logic [31:0]                     r_word;
    t_phase                          r_phase, n_phase;
    logic [wec_pkg::SKIP_W-1:0]      r_skip, n_skip;
    logic [CW-1:0]                   r_total, n_total;
    logic [CW-1:0]                   r_cell, n_cell;
    logic                            r_chan, n_chan;
    logic signed [ACC_W-1:0]         r_acc, n_acc;

    logic [CW-1:0]                   count_clamped;
    logic [CW:0]                     cell_inc;
    logic                            in_window;
    logic signed [DW-1:0]            diff;
    logic signed [ACC_W:0]           sum_wide;
    logic signed [ACC_W-1:0]         sum_sat;
    logic signed [ACC_W-1:0]         acc_upd;

    assign count_clamped = (r_word > 32'(MAX_CELLS)) ? CW'(MAX_CELLS) : r_word[CW-1:0];
    assign cell_inc      = {1'b0, r_cell} + {{CW{1'b0}}, 1'b1};
    assign in_window     = (CMPW'(i_cfg.window_start) < CMPW'(r_cell))
                        && (CMPW'(r_cell) < CMPW'(i_cfg.window_end));
    assign diff          = signed'(DW'(r_word[SAMPLE_BITS-1:0]) - DW'(i_cfg.pedestal));
    assign sum_wide      = (ACC_W+1)'(r_acc) + (ACC_W+1)'(diff);

    always_comb begin
        if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
            sum_sat = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            sum_sat = sum_wide[ACC_W-1:0];
        end
        acc_upd = in_window ? sum_sat : r_acc;
    end

    always_comb begin
        n_phase = r_phase;
        n_skip  = r_skip;
        n_total = r_total;
        n_cell  = r_cell;
        n_chan  = r_chan;
        n_acc   = r_acc;
        o_push0 = 1'b0;
        o_push1 = 1'b0;
        o_res0  = '{channel: r_chan, last: r_chan, sum: acc_upd};
        o_res1  = '{channel: 1'b1, last: 1'b1, sum: '0};
        if (r_in_valid) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (r_word == wec_pkg::HEADER_MARK) begin
                        n_phase = PH_SKIP;
                        n_skip  = '0;
                    end
                end
                PH_SKIP: begin
                    n_skip = r_skip + 1'b1;
                    if (n_skip == '0) begin
                        n_phase = PH_COUNT;
                    end
                end
                PH_COUNT: begin
                    n_total = count_clamped;
                    n_cell  = '0;
                    n_chan  = 1'b0;
                    n_acc   = '0;
                    if (count_clamped == '0) begin
                        o_push0 = 1'b1;
                        o_push1 = 1'b1;
                        o_res0  = '{channel: 1'b0, last: 1'b0, sum: '0};
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_acc  = acc_upd;
                    n_cell = cell_inc[CW-1:0];
                    if (cell_inc >= {1'b0, r_total}) begin
                        o_push0 = 1'b1;
                        n_acc   = '0;
                        n_cell  = '0;
                        n_chan  = ~r_chan;
                        if (r_chan) begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= i_valid ? i_word : r_word;
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_IDLE;
            r_skip     <= '0;
            r_total    <= '0;
            r_cell     <= '0;
            r_chan     <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_in_valid <= i_valid;
            r_phase    <= n_phase;
            r_skip     <= n_skip;
            r_total    <= n_total;
            r_cell     <= n_cell;
            r_chan     <= n_chan;
            r_acc      <= n_acc;
        end
    end

`ifndef NO_ASSERTIONS
    a_push1_pairs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push1 |-> (o_push0 && !o_res0.last && o_res1.last))
        else $error("second result without a first");

    a_cell_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_cell < r_total))
        else $error("cell index past sample count");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_phase == PH_DATA && o_push0 && r_chan) |=>
            (r_phase == PH_IDLE && !r_chan && r_acc == '0))
        else $error("event not closed after second channel");
`endif

endmodule

`default_nettype wire

// ----- src/wec_fifo.sv -----
// ----------------------------------------------------------------------------
// wec_fifo
// Result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wec_fifo (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push0,
    input  wire logic                        i_push1,
    input  wec_pkg::t_result                 i_res0,
    input  wec_pkg::t_result                 i_res1,
    output logic                             o_valid,
    input  wire logic                        i_pop,
    output wec_pkg::t_result                 o_res,
    output logic [wec_pkg::FIFO_CW-1:0]      o_count
);

    wec_pkg::t_result                r_mem [wec_pkg::FIFO_DEPTH];
    logic [wec_pkg::FIFO_AW-1:0]     r_wp;
    logic [wec_pkg::FIFO_AW-1:0]     r_rp;
    logic [wec_pkg::FIFO_CW-1:0]     r_count;
    logic [wec_pkg::FIFO_AW-1:0]     wp1;
    logic                            pop;
    logic [wec_pkg::FIFO_CW-1:0]     n_push;

    assign wp1     = r_wp + 1'b1;
    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rp];
    assign o_count = r_count;
    assign pop     = i_pop && o_valid;
    assign n_push  = wec_pkg::FIFO_CW'(i_push0) + wec_pkg::FIFO_CW'(i_push1);

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wp] <= i_res0;
        end
        if (i_push1) begin
            r_mem[wp1] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + n_push[wec_pkg::FIFO_AW-1:0];
            r_rp    <= r_rp + wec_pkg::FIFO_AW'(pop);
            r_count <= r_count + n_push - wec_pkg::FIFO_CW'(pop);
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (({1'b0, r_count} + {1'b0, n_push}) <= (wec_pkg::FIFO_CW+1)'(wec_pkg::FIFO_DEPTH)))
        else $error("result queue overflow");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) || (r_wp != r_rp) || (r_count == wec_pkg::FIFO_CW'(wec_pkg::FIFO_DEPTH)))
        else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

// ----- verif/waveform_event_charge_integrator_test.sv -----
// ----------------------------------------------------------------------------
// waveform_event_charge_integrator_test
// Self-checking bench for the waveform event charge integrator. Drives event
// word streams (noise, header, count, two channels of samples) and compares
// every per-channel charge against a cycle-free model of the parser and
// window summing. Runs through several window, pedestal and shift settings
// with random idle gaps on the input and random stalls on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module waveform_event_charge_integrator_test;

    localparam int MAX_CELLS   = 1024;
    localparam int SAMPLE_BITS = 12;
    localparam int HDR_WORDS   = 8;
    localparam int ACC_HI      = 8388607;
    localparam int ACC_LO      = -8388608;
    localparam int CHG_HI      = 4194303;
    localparam int CHG_LO      = -4194304;
    localparam int PHASE_WORDS = 185;
    localparam int SETTLE_CYC  = 8;

    typedef enum logic [1:0] {ST_HUNT, ST_SKIP, ST_COUNT, ST_SAMPLES} t_parse_state;

    typedef struct {
        logic                                channel;
        logic signed [wec_pkg::CHARGE_W-1:0] charge;
        logic                                closes;
    } t_charge_rec;

    class charge_scoreboard;
        logic [wec_pkg::WIN_W-1:0]   win_lo = wec_pkg::RST_WINDOW_START;
        logic [wec_pkg::WIN_W-1:0]   win_hi = wec_pkg::RST_WINDOW_END;
        logic [wec_pkg::PED_W-1:0]   ped    = wec_pkg::RST_PEDESTAL;
        logic [wec_pkg::SHIFT_W-1:0] shift  = wec_pkg::RST_CHARGE_SHIFT;
        t_parse_state                state  = ST_HUNT;
        int                          skipped;
        int                          total;
        int                          cell_idx;
        int                          acc;
        logic                        chan;
        t_charge_rec                 expected_charges[$];
        int                          errors;

        function void write_reg(logic [wec_pkg::CFG_IW-1:0] idx,
                                logic [wec_pkg::CFG_DW-1:0] data);
            case (idx)
                wec_pkg::REG_WINDOW_START: win_lo = data[wec_pkg::WIN_W-1:0];
                wec_pkg::REG_WINDOW_END:   win_hi = data[wec_pkg::WIN_W-1:0];
                wec_pkg::REG_PEDESTAL:     ped    = data[wec_pkg::PED_W-1:0];
                wec_pkg::REG_CHARGE_SHIFT: shift  = data[wec_pkg::SHIFT_W-1:0];
            endcase
        endfunction

        function void push(logic ch, int q, logic fin);
            t_charge_rec e;
            if (q > CHG_HI) q = CHG_HI;
            if (q < CHG_LO) q = CHG_LO;
            e.channel = ch;
            e.charge  = q[wec_pkg::CHARGE_W-1:0];
            e.closes  = fin;
            expected_charges.insert(expected_charges.size(), e);
        endfunction

        function int pending();
            return expected_charges.size();
        endfunction

        // one accepted stream word
        function void note_word(logic [31:0] w);
            int s;
            case (state)
                ST_HUNT: begin
                    if (w == wec_pkg::HEADER_MARK) begin
                        state   = ST_SKIP;
                        skipped = 0;
                    end
                end
                ST_SKIP: begin
                    skipped++;
                    if (skipped == HDR_WORDS) state = ST_COUNT;
                end
                ST_COUNT: begin
                    total    = (w > MAX_CELLS) ? MAX_CELLS : int'(w);
                    cell_idx = 0;
                    chan     = 1'b0;
                    acc      = 0;
                    if (total == 0) begin
                        push(1'b0, 0, 1'b0);
                        push(1'b1, 0, 1'b1);
                        state = ST_HUNT;
                    end else begin
                        state = ST_SAMPLES;
                    end
                end
                ST_SAMPLES: begin
                    if (int'(win_lo) < cell_idx && cell_idx < int'(win_hi)) begin
                        s = acc + int'(w[SAMPLE_BITS-1:0]) - int'(ped);
                        if (s > ACC_HI) s = ACC_HI;
                        if (s < ACC_LO) s = ACC_LO;
                        acc = s;
                    end
                    cell_idx++;
                    if (cell_idx >= total) begin
                        push(chan, acc >>> shift, chan);
                        acc      = 0;
                        cell_idx = 0;
                        if (chan) begin
                            chan  = 1'b0;
                            state = ST_HUNT;
                        end else begin
                            chan = 1'b1;
                        end
                    end
                end
            endcase
        endfunction

        function void check_result(logic ch, logic signed [wec_pkg::CHARGE_W-1:0] q,
                                   logic fin);
            t_charge_rec e;
            if (expected_charges.size() == 0) begin
                $error("unexpected result: channel %0d charge %0d last %0d", ch, q, fin);
                errors++;
                return;
            end
            e = expected_charges.pop_front();
            if (ch !== e.channel) begin
                $error("channel: expected %0d, got %0d", e.channel, ch);
                errors++;
            end
            if (q !== e.charge) begin
                $error("charge: expected %0d, got %0d", e.charge, q);
                errors++;
            end
            if (fin !== e.closes) begin
                $error("last: expected %0d, got %0d", e.closes, fin);
                errors++;
            end
        endfunction
    endclass

    logic                                i_clk       = 1'b0;
    logic                                i_rst_n     = 1'b0;
    logic                                i_valid     = 1'b0;
    logic [31:0]                         i_word      = '0;
    logic                                i_stall     = 1'b0;
    logic                                i_cfg_valid = 1'b0;
    logic [wec_pkg::CFG_IW-1:0]          i_cfg_index = '0;
    logic [wec_pkg::CFG_DW-1:0]          i_cfg_data  = '0;
    logic                                o_stall;
    logic                                o_valid;
    logic                                o_channel;
    logic signed [wec_pkg::CHARGE_W-1:0] o_charge;
    logic                                o_last;
    logic                                o_cfg_ready;

    charge_scoreboard sb;
    int               gap_pct;
    int               stall_pct;
    int               words_sent;

    waveform_event_charge_integrator #(
        .MAX_CELLS   (MAX_CELLS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_word      (i_word),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_channel   (o_channel),
        .o_charge    (o_charge),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // result side: check each transfer, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_channel, o_charge, o_last);
        end
        i_stall <= ($urandom_range(99, 0) < stall_pct);
    end

    task automatic send_word(input logic [31:0] w);
        while ($urandom_range(99, 0) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= w;
        do @(posedge i_clk); while (o_stall);
        sb.note_word(w);
        words_sent++;
    endtask

    function automatic logic [31:0] sample_word();
        logic [31:0] s;
        s = $urandom;
        case ($urandom_range(7, 0))
            0: s[SAMPLE_BITS-1:0] = '0;
            1: s[SAMPLE_BITS-1:0] = '1;
            default: ;
        endcase
        return s;
    endfunction

    // noise, header, skipped words, count and both channels, or a cut-off header
    task automatic send_event(input logic [31:0] count_word, input bit broken);
        int n;
        n = (count_word > MAX_CELLS) ? MAX_CELLS : int'(count_word);
        repeat ($urandom_range(2, 0)) send_word($urandom);
        send_word(wec_pkg::HEADER_MARK);
        if (broken) begin
            repeat ($urandom_range(7, 0)) send_word($urandom);
            // cut-off header, padded with zero words into an empty event
            while (sb.state != ST_HUNT) send_word(32'h0000_0000);
            return;
        end
        repeat (HDR_WORDS) begin
            send_word(($urandom_range(7, 0) == 0) ? wec_pkg::HEADER_MARK : 32'($urandom));
        end
        send_word(count_word);
        repeat (2 * n) send_word(sample_word());
    endtask

    // stop sending until every expected charge is out
    task automatic drain(input bit settle);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        if (settle) repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_one(input logic [wec_pkg::CFG_IW-1:0] idx,
                             input logic [wec_pkg::CFG_DW-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, d);
    endtask

    task automatic write_regs(input logic [wec_pkg::CFG_DW-1:0] lo,
                              input logic [wec_pkg::CFG_DW-1:0] hi,
                              input logic [wec_pkg::CFG_DW-1:0] ped,
                              input logic [wec_pkg::CFG_DW-1:0] sh);
        write_one(wec_pkg::REG_WINDOW_START, lo);
        write_one(wec_pkg::REG_WINDOW_END, hi);
        write_one(wec_pkg::REG_PEDESTAL, ped);
        write_one(wec_pkg::REG_CHARGE_SHIFT, sh);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int  start_words;
        int  r;
        bit  drained;
        logic [31:0] cnt;

        sb         = new();
        gap_pct    = 0;
        stall_pct  = 0;
        words_sent = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: noise, near-miss mark, mark inside header, zero count, short event
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        send_word(wec_pkg::HEADER_MARK ^ 32'h1);
        send_word(wec_pkg::HEADER_MARK);
        send_word(wec_pkg::HEADER_MARK);
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        send_word(wec_pkg::HEADER_MARK);
        repeat (4) send_word($urandom);
        send_word(32'h0000_0000);
        send_word(wec_pkg::HEADER_MARK);
        repeat (HDR_WORDS) send_word($urandom);
        send_word(32'h0000_0002);
        send_word(32'hFFFF_FFFF);
        send_word(32'h0000_0000);
        send_word(32'hFFFF_F000);
        send_word(32'h0000_0FFF);
        drain(1'b1);

        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 78; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 78; end
                default: begin gap_pct = 36; stall_pct = 36; end
            endcase
            case (p)
                0: write_regs(12'd0, 12'd12, 12'd0, 12'd0);
                1: write_regs(12'd3, 12'd20, 12'd4095, 12'd15);
                // bits above the register widths are dropped; window comes out empty
                2: write_regs(12'hFFF, 12'h800, 12'h7FF, 12'hFF7);
                4: write_regs(12'd0, 12'd1024, 12'd0, 12'd0);
                default: write_regs(wec_pkg::CFG_DW'($urandom_range(10, 0)),
                                    wec_pkg::CFG_DW'($urandom_range(28, 0)),
                                    wec_pkg::CFG_DW'($urandom_range(4095, 0)),
                                    wec_pkg::CFG_DW'($urandom_range(15, 0)));
            endcase
            start_words = words_sent;
            drained     = 1'b0;
            while (words_sent - start_words < PHASE_WORDS) begin
                r = $urandom_range(99, 0);
                if (r < 10) cnt = 0;
                else if (r < 14) cnt = 1;
                else cnt = $urandom_range(24, 2);
                send_event(cnt, $urandom_range(99, 0) < 8);
                if (!drained && words_sent - start_words > PHASE_WORDS / 2) begin
                    drain(1'b0);
                    drained = 1'b1;
                end
            end
            drain(1'b1);
        end

        // oversized count, held at the full cell range: no charge within these samples
        send_word(wec_pkg::HEADER_MARK);
        repeat (HDR_WORDS) send_word($urandom);
        send_word(32'h0001_0002);
        repeat (40) send_word(sample_word());
        drain(1'b1);

        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- waveform_event_charge_integrator.f -----
src/wec_pkg.sv
src/wec_cfg.sv
src/wec_core.sv
src/wec_fifo.sv
src/waveform_event_charge_integrator.sv
verif/waveform_event_charge_integrator_test.sv
